/* sv/adpcm_pkg.sv */
`timescale 1ns / 1ps
// adpcm_pkg: shared widths, limits, sequencer states and the step adaptation table
// for the ADPCM nibble decoder. No dependencies.
package adpcm_pkg;

  localparam int unsigned STEP_W = 15;
  localparam int unsigned FACT_W = 10;
  localparam int unsigned PROD_W = 25;

  localparam logic [STEP_W-1:0] STEP_MIN = 15'd127;
  localparam logic [STEP_W-1:0] STEP_MAX = 15'd24576;
  localparam logic [STEP_W-1:0] DIFF_CAP = 15'd32767;

  localparam logic signed [15:0] HIST_MAX = 16'sh7fff;
  localparam logic signed [15:0] HIST_MIN = 16'sh8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_STEP,
    ST_UPD,
    ST_EMIT
  } state_t;

  function automatic logic [FACT_W-1:0] adapt_factor(input logic [2:0] mag);
    logic [FACT_W-1:0] f;
    unique case (mag)
      3'd4:    f = 10'd307;
      3'd5:    f = 10'd409;
      3'd6:    f = 10'd512;
      3'd7:    f = 10'd614;
      default: f = 10'd230;
    endcase
    return f;
  endfunction

endpackage

/* sv/adpcm_if.sv */
`timescale 1ns / 1ps
// Channel interfaces for the ADPCM nibble decoder: input bytes, output samples,
// and the mode register write channel. Depends on nothing.
interface adpcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;
  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface adpcm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last;
  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface adpcm_cfg_if;
  logic valid;
  logic ready;
  logic pcm_mode;
  modport source (output valid, output pcm_mode, input ready);
  modport sink   (input valid, input pcm_mode, output ready);
endinterface

/* sv/adpcm_mul.sv */
`timescale 1ns / 1ps
// adpcm_mul: shared multiplier with registered product, used for both the
// difference and the step adaptation. Depends on adpcm_pkg.
module adpcm_mul (
  input  logic                             clk,
  input  logic [adpcm_pkg::FACT_W-1:0]     fact,
  input  logic [adpcm_pkg::STEP_W-1:0]     step,
  output logic [adpcm_pkg::PROD_W-1:0]     prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= adpcm_pkg::PROD_W'(fact) * adpcm_pkg::PROD_W'(step);
  end

endmodule

/* sv/adpcm_nibble_decoder.sv */
`timescale 1ns / 1ps
// adpcm_nibble_decoder: top level; sequencer around one shared multiplier.
// Depends on adpcm_pkg, adpcm_if.sv (interfaces) and adpcm_mul.
//
//  channel  | dir | payload                  | handshake
//  ---------+-----+--------------------------+-------------
//  in_if    | in  | data_byte[7:0], restart  | valid/ready
//  out_if   | out | sample[15:0] s, last     | valid/ready
//  cfg_if   | in  | pcm_mode                 | valid/ready
//
// ADPCM byte: accepted while idle, then for each nibble a diff multiply, a step
// multiply, an update and the hand-off to the output register.
// PCM: first byte of a pair is stored as the low byte, second byte is emitted.
// in_if.ready is high only while the sequencer is idle; a full output register
// holds the sequencer in its hand-off state. cfg_if is always ready.
// Synchronous active-low reset: history 0, step 127, pairing cleared, ADPCM mode.
module adpcm_nibble_decoder (
  input  logic              clk,
  input  logic              rst_n,
  adpcm_in_if.sink          in_if,
  adpcm_out_if.source       out_if,
  adpcm_cfg_if.sink         cfg_if
);

  adpcm_pkg::state_t state_r, state_nxt;

  logic                            pcm_mode_r;
  logic signed [15:0]              hist_r, hist_nxt;
  logic [adpcm_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic [7:0]                      low_r, low_nxt;
  logic                            have_low_r, have_low_nxt;
  logic [7:0]                      byte_r, byte_nxt;
  logic                            nib_r, nib_nxt;
  logic [adpcm_pkg::STEP_W-1:0]    diff_r, diff_nxt;
  logic signed [15:0]              res_r, res_nxt;
  logic                            res_last_r, res_last_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic signed [15:0]              out_sample_r, out_sample_nxt;
  logic                            out_last_r, out_last_nxt;

  logic [adpcm_pkg::FACT_W-1:0]    mul_fact;
  logic [adpcm_pkg::PROD_W-1:0]    prod_r;

  logic [3:0]                      code;
  logic                            have_low_eff;
  logic signed [16:0]              sum;
  logic signed [15:0]              sat;
  logic [16:0]                     nstep;

  adpcm_mul u_mul (
    .clk    (clk),
    .fact   (mul_fact),
    .step   (step_r),
    .prod_r (prod_r)
  );

  assign code = nib_r ? byte_r[7:4] : byte_r[3:0];

  assign in_if.ready   = (state_r == adpcm_pkg::ST_IDLE);
  assign cfg_if.ready  = 1'b1;
  assign out_if.valid  = out_valid_r;
  assign out_if.sample = out_sample_r;
  assign out_if.last   = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    hist_nxt       = hist_r;
    step_nxt       = step_r;
    low_nxt        = low_r;
    have_low_nxt   = have_low_r;
    byte_nxt       = byte_r;
    nib_nxt        = nib_r;
    diff_nxt       = diff_r;
    res_nxt        = res_r;
    res_last_nxt   = res_last_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    mul_fact       = '0;
    have_low_eff   = have_low_r && !in_if.restart;
    sum            = '0;
    sat            = '0;
    nstep          = '0;

    unique case (state_r)
      adpcm_pkg::ST_IDLE: begin
        if (in_if.valid) begin
          if (in_if.restart) begin
            hist_nxt     = '0;
            step_nxt     = adpcm_pkg::STEP_MIN;
            low_nxt      = '0;
            have_low_nxt = 1'b0;
          end
          if (pcm_mode_r) begin
            if (!have_low_eff) begin
              low_nxt      = in_if.data_byte;
              have_low_nxt = 1'b1;
            end else begin
              res_nxt      = {in_if.data_byte, low_r};
              res_last_nxt = 1'b1;
              have_low_nxt = 1'b0;
              state_nxt    = adpcm_pkg::ST_EMIT;
            end
          end else begin
            byte_nxt     = in_if.data_byte;
            nib_nxt      = 1'b0;
            have_low_nxt = 1'b0;
            state_nxt    = adpcm_pkg::ST_DIFF;
          end
        end
      end
      adpcm_pkg::ST_DIFF: begin
        mul_fact  = adpcm_pkg::FACT_W'({code[2:0], 1'b1});
        state_nxt = adpcm_pkg::ST_STEP;
      end
      adpcm_pkg::ST_STEP: begin
        diff_nxt  = (|prod_r[24:18]) ? adpcm_pkg::DIFF_CAP : prod_r[17:3];
        mul_fact  = adpcm_pkg::adapt_factor(code[2:0]);
        state_nxt = adpcm_pkg::ST_UPD;
      end
      adpcm_pkg::ST_UPD: begin
        if (code[3]) begin
          sum = {hist_r[15], hist_r} - $signed({2'b00, diff_r});
        end else begin
          sum = {hist_r[15], hist_r} + $signed({2'b00, diff_r});
        end
        if (sum[16] != sum[15]) begin
          sat = sum[16] ? adpcm_pkg::HIST_MIN : adpcm_pkg::HIST_MAX;
        end else begin
          sat = sum[15:0];
        end
        nstep = prod_r[24:8];
        if (nstep < 17'(adpcm_pkg::STEP_MIN)) begin
          step_nxt = adpcm_pkg::STEP_MIN;
        end else if (nstep > 17'(adpcm_pkg::STEP_MAX)) begin
          step_nxt = adpcm_pkg::STEP_MAX;
        end else begin
          step_nxt = nstep[14:0];
        end
        hist_nxt     = sat;
        res_nxt      = sat;
        res_last_nxt = nib_r;
        state_nxt    = adpcm_pkg::ST_EMIT;
      end
      adpcm_pkg::ST_EMIT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = res_r;
          out_last_nxt   = res_last_r;
          if (res_last_r) begin
            state_nxt = adpcm_pkg::ST_IDLE;
          end else begin
            nib_nxt   = 1'b1;
            state_nxt = adpcm_pkg::ST_DIFF;
          end
        end
      end
      default: begin
        state_nxt = adpcm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= adpcm_pkg::ST_IDLE;
      pcm_mode_r  <= 1'b0;
      hist_r      <= '0;
      step_r      <= adpcm_pkg::STEP_MIN;
      low_r       <= '0;
      have_low_r  <= 1'b0;
      nib_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hist_r      <= hist_nxt;
      step_r      <= step_nxt;
      low_r       <= low_nxt;
      have_low_r  <= have_low_nxt;
      nib_r       <= nib_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid) begin
        pcm_mode_r <= cfg_if.pcm_mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r       <= byte_nxt;
    diff_r       <= diff_nxt;
    res_r        <= res_nxt;
    res_last_r   <= res_last_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

  // step stays inside its clamp window
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r >= adpcm_pkg::STEP_MIN && step_r <= adpcm_pkg::STEP_MAX)
    else $error("step out of range");

  // ADPCM byte starts decoding and drops any pending PCM low byte
  a_adpcm_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready && !pcm_mode_r |=>
      state_r == adpcm_pkg::ST_DIFF && !have_low_r && !nib_r)
    else $error("ADPCM transaction did not start decode");

  // hand-off moves the pending result into the output register
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == adpcm_pkg::ST_EMIT && (!out_valid_r || out_if.ready) |=>
      out_if.valid && out_if.sample == $past(res_r) && out_if.last == $past(res_last_r))
    else $error("result lost at hand-off");

endmodule
